FILE: hdl/asca_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// asca_pkg
// Shared types, codes and sizing constants of the attention-state capacity
// admission controller.
// ----------------------------------------------------------------------------
package asca_pkg;

  localparam int unsigned SeqSlotsDefault   = 256;
  localparam int unsigned LayerCountDefault = 43;

  localparam int unsigned SeqW      = 8;
  localparam int unsigned LayerW    = 6;
  localparam int unsigned CtxW      = 21;
  localparam int unsigned BytesW    = 33;
  localparam int unsigned GenW      = 32;
  localparam int unsigned TotalW    = 40;
  localparam int unsigned ModeW     = 2;
  localparam int unsigned StatusW   = 3;

  localparam int unsigned InDataW   = 48;
  localparam int unsigned OutDataW  = 152;

  // Per-layer sizing rule.
  localparam logic [19:0] ShallowLayerBytes = 20'd131072;
  localparam logic [29:0] EvenBaseBytes     = 30'd212992;
  localparam logic [29:0] EvenStepBytes     = 30'd1280;
  localparam logic [29:0] OddBaseBytes      = 30'd655360;
  localparam logic [29:0] OddStepBytes      = 30'd1024;
  localparam logic [19:0] ExtraBlockBytes   = 20'd393216;
  localparam logic [CtxW-1:0] MaxContext    = 21'd1048576;
  localparam int unsigned EvenCtxShift      = 2;
  localparam int unsigned OddCtxShift       = 7;

  typedef enum logic [ModeW-1:0] {
    MODE_RESERVE  = 2'd0,
    MODE_PUBLISH  = 2'd1,
    MODE_ROLLBACK = 2'd2,
    MODE_RELEASE  = 2'd3
  } mode_e;

  typedef enum logic [StatusW-1:0] {
    STAT_OK            = 3'd0,
    STAT_BAD_ARG       = 3'd1,
    STAT_ALREADY_LIVE  = 3'd2,
    STAT_NO_CAPACITY   = 3'd3,
    STAT_GEN_EXHAUSTED = 3'd4,
    STAT_NOT_RESERVED  = 3'd5,
    STAT_NOT_PUBLISHED = 3'd6
  } status_e;

  typedef enum logic [1:0] {
    SLOT_FREE      = 2'd0,
    SLOT_RESERVED  = 2'd1,
    SLOT_PUBLISHED = 2'd2
  } slot_state_e;

  typedef enum logic [1:0] {
    FSM_IDLE   = 2'd0,
    FSM_SIZE   = 2'd1,
    FSM_LEFT   = 2'd2,
    FSM_DECIDE = 2'd3
  } fsm_state_e;

  typedef struct packed {
    slot_state_e       state;
    logic [BytesW-1:0] bytes;
    logic [GenW-1:0]   gen;
  } slot_entry_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } mem_req_t;

endpackage : asca_pkg
`default_nettype wire

FILE: hdl/asca_sizer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// asca_sizer
// Three-stage request sizing: layer counts and per-layer costs, products,
// then the sum with saturation to the byte field width.
// ----------------------------------------------------------------------------
module asca_sizer #(
  parameter int unsigned LAYER_COUNT = asca_pkg::LayerCountDefault
) (
  input  wire logic                          clk_i,
  input  wire logic                          load_i,
  input  wire logic [asca_pkg::LayerW-1:0]   layer_lo_i,
  input  wire logic [asca_pkg::LayerW-1:0]   layer_hi_i,
  input  wire logic                          owns_extra_i,
  input  wire logic [asca_pkg::CtxW-1:0]     context_len_i,
  output logic                               bad_o,
  output logic [asca_pkg::BytesW-1:0]        size_o
);
  import asca_pkg::*;

  localparam logic [LayerW:0] LayerLimit = (LayerW + 1)'(LAYER_COUNT);

  logic [LayerW-1:0] lo_layer;
  logic              deep;
  logic [LayerW-1:0] n_even_d, n_odd_d;
  logic [1:0]        n_low_d;
  logic [LayerW:0]   last_inc;
  logic [29:0]       cost_even_d, cost_odd_d;
  logic              bad_d;

  logic              bad_q;
  logic [1:0]        n_low_q;
  logic [LayerW-1:0] n_even_q, n_odd_q;
  logic [29:0]       cost_even_q, cost_odd_q;
  logic              extra_q;

  logic [35:0]       prod_even_q, prod_odd_q;
  logic [19:0]       base_q;
  logic [37:0]       sum;
  logic [BytesW-1:0] size_q;

  always_comb begin
    // Layers 0 and 1 have a flat cost; the alternating rule starts at layer 2.
    lo_layer = (layer_lo_i < LayerW'(2)) ? LayerW'(2) : layer_lo_i;
    deep     = layer_hi_i >= LayerW'(2);
    last_inc = {1'b0, layer_hi_i} + (LayerW + 1)'(1);
    n_even_d = deep ? LayerW'((layer_hi_i >> 1) - ((lo_layer - LayerW'(1)) >> 1)) : '0;
    n_odd_d  = deep ? LayerW'(last_inc >> 1) - LayerW'(lo_layer >> 1) : '0;
    n_low_d  = 2'(layer_lo_i == '0)
             + 2'((layer_lo_i <= LayerW'(1)) && (layer_hi_i >= LayerW'(1)));
    cost_even_d = EvenBaseBytes + 30'(context_len_i >> EvenCtxShift) * EvenStepBytes;
    cost_odd_d  = OddBaseBytes + 30'(context_len_i >> OddCtxShift) * OddStepBytes;
    bad_d = (layer_lo_i > layer_hi_i) || ({1'b0, layer_hi_i} >= LayerLimit)
         || (context_len_i == '0) || (context_len_i > MaxContext);
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      bad_q       <= bad_d;
      n_low_q     <= n_low_d;
      n_even_q    <= n_even_d;
      n_odd_q     <= n_odd_d;
      cost_even_q <= cost_even_d;
      cost_odd_q  <= cost_odd_d;
      extra_q     <= owns_extra_i;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_even_q <= 36'(n_even_q) * 36'(cost_even_q);
    prod_odd_q  <= 36'(n_odd_q) * 36'(cost_odd_q);
    base_q      <= 20'(n_low_q) * ShallowLayerBytes + (extra_q ? ExtraBlockBytes : '0);
  end

  assign sum = 38'(prod_even_q) + 38'(prod_odd_q) + 38'(base_q);

  always_ff @(posedge clk_i) begin
    size_q <= (sum > 38'({BytesW{1'b1}})) ? {BytesW{1'b1}} : sum[BytesW-1:0];
  end

  assign bad_o  = bad_q;
  assign size_o = size_q;

endmodule : asca_sizer
`default_nettype wire

FILE: hdl/asca_slot_store.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// asca_slot_store
// Per-slot entry memory with a registered read port and a clearing sweep
// that marks every slot free after reset.
// ----------------------------------------------------------------------------
module asca_slot_store #(
  parameter int unsigned SEQ_SLOTS = asca_pkg::SeqSlotsDefault,
  localparam int unsigned IdxW     = (SEQ_SLOTS > 1) ? $clog2(SEQ_SLOTS) : 1
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire asca_pkg::mem_req_t    req_i,
  input  wire logic [IdxW-1:0]       rd_addr_i,
  input  wire logic [IdxW-1:0]       wr_addr_i,
  input  wire asca_pkg::slot_entry_t wr_entry_i,
  output asca_pkg::slot_entry_t      rd_entry_o,
  output logic                       ready_o
);
  import asca_pkg::*;

  localparam logic [IdxW-1:0] LastIdx = IdxW'(SEQ_SLOTS - 1);

  slot_entry_t     slot_mem_q [SEQ_SLOTS];
  slot_entry_t     rd_entry_q;
  logic [IdxW-1:0] clr_idx_q, clr_idx_d;
  logic            clearing_q, clearing_d;

  always_comb begin
    clr_idx_d  = clr_idx_q;
    clearing_d = clearing_q;
    if (clearing_q) begin
      clr_idx_d = clr_idx_q + IdxW'(1);
      if (clr_idx_q == LastIdx) begin
        clearing_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_idx_q  <= '0;
      clearing_q <= 1'b1;
    end else begin
      clr_idx_q  <= clr_idx_d;
      clearing_q <= clearing_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (clearing_q) begin
      slot_mem_q[clr_idx_q] <= '{state: SLOT_FREE, bytes: '0, gen: '0};
    end else if (req_i.wr_en) begin
      slot_mem_q[wr_addr_i] <= wr_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      rd_entry_q <= slot_mem_q[rd_addr_i];
    end
  end

  assign rd_entry_o = rd_entry_q;
  assign ready_o    = !clearing_q;

endmodule : asca_slot_store
`default_nettype wire

FILE: hdl/attention_state_capacity_admission.sv
`timescale 1ns / 1ps
`default_nettype none
// Pipeline: an accepted item passes the per-layer costs and slot read, the products,
// the saturated sum, then the decision into the output register.
// Throughput: a new item is taken only on the return to idle after the three sizing
// stages and decision; a result held by the receiver stalls the decision and input.
// Reset: all totals clear, the next generation is one, and a clearing sweep
// marks every slot free; no item is taken until it ends.
// ----------------------------------------------------------------------------
// attention_state_capacity_admission
// Admission controller for per-sequence attention-state memory: reserve,
// publish, rollback and release against a configurable byte capacity.
// ----------------------------------------------------------------------------
module attention_state_capacity_admission #(
  parameter int unsigned SEQ_SLOTS   = asca_pkg::SeqSlotsDefault,
  parameter int unsigned LAYER_COUNT = asca_pkg::LayerCountDefault
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [asca_pkg::TotalW-1:0]   cfg_wdata_i,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // seq_id[7:0], layer_lo[13:8], layer_hi[19:14], owns_extra[20],
  // context_len[41:21], zero padding above.
  input  wire logic [asca_pkg::InDataW-1:0]  s_axis_tdata,
  // mode[1:0]
  input  wire logic [asca_pkg::ModeW-1:0]    s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // status[2:0], bytes[35:3], generation[67:36], reserved_total[107:68],
  // owned_total[147:108], zero padding above.
  output logic [asca_pkg::OutDataW-1:0]      m_axis_tdata
);
  import asca_pkg::*;

  localparam int unsigned IdxW = (SEQ_SLOTS > 1) ? $clog2(SEQ_SLOTS) : 1;
  localparam logic [16:0] SlotLimit = 17'(SEQ_SLOTS);

  fsm_state_e state_q, state_d;

  logic            in_fire, advance, store_ready;
  logic [SeqW+IdxW-1:0] seq_ext;
  logic [IdxW-1:0] rd_addr;

  mode_e           mode_q;
  logic [IdxW-1:0] addr_q;
  logic            slot_ok_q;

  logic [TotalW-1:0] capacity_q;
  logic [TotalW-1:0] reserved_q, reserved_d;
  logic [TotalW-1:0] owned_q, owned_d;
  logic [GenW-1:0]   next_gen_q, next_gen_d;
  logic [TotalW-1:0] left_q;
  logic [TotalW:0]   used;

  mem_req_t          mem_req;
  slot_entry_t       entry, wr_entry;
  logic              size_bad;
  logic [BytesW-1:0] size;

  status_e           res_status;
  logic [BytesW-1:0] res_bytes;
  logic [GenW-1:0]   res_gen;
  logic [BytesW-1:0] held_bytes;
  logic [GenW-1:0]   held_gen;
  logic              do_write;

  logic                out_valid_q, out_valid_d;
  logic [OutDataW-1:0] out_data_q, out_data_d;

  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign advance = !out_valid_q || m_axis_tready;
  assign seq_ext = {{IdxW{1'b0}}, s_axis_tdata[SeqW-1:0]};
  assign rd_addr = seq_ext[IdxW-1:0];

  asca_sizer #(
    .LAYER_COUNT (LAYER_COUNT)
  ) u_sizer (
    .clk_i         (clk_i),
    .load_i        (in_fire),
    .layer_lo_i    (s_axis_tdata[13:8]),
    .layer_hi_i    (s_axis_tdata[19:14]),
    .owns_extra_i  (s_axis_tdata[20]),
    .context_len_i (s_axis_tdata[41:21]),
    .bad_o         (size_bad),
    .size_o        (size)
  );

  asca_slot_store #(
    .SEQ_SLOTS (SEQ_SLOTS)
  ) u_slot_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (mem_req),
    .rd_addr_i  (rd_addr),
    .wr_addr_i  (addr_q),
    .wr_entry_i (wr_entry),
    .rd_entry_o (entry),
    .ready_o    (store_ready)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      FSM_IDLE:   if (in_fire) state_d = FSM_SIZE;
      FSM_SIZE:   state_d = FSM_LEFT;
      FSM_LEFT:   state_d = FSM_DECIDE;
      FSM_DECIDE: if (advance) state_d = FSM_IDLE;
      default:    state_d = FSM_IDLE;
    endcase
  end

  // Decision on the entry read back from the slot memory.
  always_comb begin
    held_bytes = (entry.state != SLOT_FREE) ? entry.bytes : '0;
    held_gen   = (entry.state != SLOT_FREE) ? entry.gen : '0;
    res_status = STAT_OK;
    res_bytes  = '0;
    res_gen    = '0;
    reserved_d = reserved_q;
    owned_d    = owned_q;
    next_gen_d = next_gen_q;
    do_write   = 1'b0;
    wr_entry   = entry;
    if (!slot_ok_q) begin
      res_status = STAT_BAD_ARG;
    end else begin
      unique case (mode_q)
        MODE_RESERVE: begin
          if (size_bad) begin
            res_status = STAT_BAD_ARG;
          end else begin
            res_bytes = size;
            if (entry.state != SLOT_FREE) begin
              res_status = STAT_ALREADY_LIVE;
            end else if (TotalW'(size) > left_q) begin
              res_status = STAT_NO_CAPACITY;
            end else if (next_gen_q == '0) begin
              res_status = STAT_GEN_EXHAUSTED;
            end else begin
              res_gen    = next_gen_q;
              next_gen_d = next_gen_q + GenW'(1);
              reserved_d = reserved_q + TotalW'(size);
              do_write   = 1'b1;
              wr_entry   = '{state: SLOT_RESERVED, bytes: size, gen: next_gen_q};
            end
          end
        end
        MODE_PUBLISH: begin
          res_bytes = held_bytes;
          res_gen   = held_gen;
          if (entry.state != SLOT_RESERVED) begin
            res_status = STAT_NOT_RESERVED;
          end else begin
            reserved_d     = reserved_q - TotalW'(held_bytes);
            owned_d        = owned_q + TotalW'(held_bytes);
            do_write       = 1'b1;
            wr_entry.state = SLOT_PUBLISHED;
          end
        end
        MODE_ROLLBACK: begin
          res_bytes = held_bytes;
          res_gen   = held_gen;
          // Rolling back a free slot is a no-op that still reports ok.
          if (entry.state == SLOT_PUBLISHED) begin
            res_status = STAT_NOT_RESERVED;
          end else if (entry.state == SLOT_RESERVED) begin
            reserved_d     = reserved_q - TotalW'(held_bytes);
            do_write       = 1'b1;
            wr_entry.state = SLOT_FREE;
          end
        end
        MODE_RELEASE: begin
          res_bytes = held_bytes;
          res_gen   = held_gen;
          if (entry.state != SLOT_PUBLISHED) begin
            res_status = STAT_NOT_PUBLISHED;
          end else begin
            owned_d        = owned_q - TotalW'(held_bytes);
            do_write       = 1'b1;
            wr_entry.state = SLOT_FREE;
          end
        end
        default: res_status = STAT_BAD_ARG;
      endcase
    end
  end

  // Outputs of the state machine.
  always_comb begin
    s_axis_tready = 1'b0;
    mem_req       = '{rd_en: 1'b0, wr_en: 1'b0};
    out_valid_d   = out_valid_q && !m_axis_tready;
    out_data_d    = out_data_q;
    unique case (state_q)
      FSM_IDLE: begin
        s_axis_tready = store_ready;
        mem_req.rd_en = s_axis_tvalid && store_ready;
      end
      FSM_DECIDE: begin
        if (advance) begin
          mem_req.wr_en = do_write;
          out_valid_d   = 1'b1;
          out_data_d    = {4'd0, owned_d, reserved_d, res_gen, res_bytes, res_status};
        end
      end
      default: begin
      end
    endcase
  end

  // Capacity left; a capacity written below the totals counts as none left.
  assign used = {1'b0, reserved_q} + {1'b0, owned_q};

  always_ff @(posedge clk_i) begin
    left_q <= (used > {1'b0, capacity_q}) ? '0 : capacity_q - used[TotalW-1:0];
    if (in_fire) begin
      mode_q    <= mode_e'(s_axis_tuser);
      addr_q    <= rd_addr;
      slot_ok_q <= {{(17 - SeqW){1'b0}}, s_axis_tdata[SeqW-1:0]} < SlotLimit;
    end
    if (state_q == FSM_DECIDE && advance) begin
      out_data_q <= out_data_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FSM_IDLE;
      capacity_q  <= '0;
      reserved_q  <= '0;
      owned_q     <= '0;
      next_gen_q  <= GenW'(1);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        capacity_q <= cfg_wdata_i;
      end
      if (state_q == FSM_DECIDE && advance) begin
        reserved_q <= reserved_d;
        owned_q    <= owned_d;
        next_gen_q <= next_gen_d;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule : attention_state_capacity_admission
`default_nettype wire

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the attention-state capacity admission controller.
// A scoreboard class predicts each result from the accepted requests and the
// capacity setting and checks the output stream in order. A directed part
// covers argument errors and the slot lifecycle; random phases follow under
// several capacity settings, random gaps in most phases, one long output stall.
// ----------------------------------------------------------------------------
module tb;
  import asca_pkg::*;

  localparam int unsigned SlotCount = 256;
  localparam int unsigned LayerLimit = 43;
  localparam int unsigned ContextMax = 1048576;
  localparam longint unsigned ShallowCost = 131072;
  localparam longint unsigned EvenBase = 212992;
  localparam longint unsigned EvenStep = 1280;
  localparam longint unsigned OddBase = 655360;
  localparam longint unsigned OddStep = 1024;
  localparam longint unsigned ExtraBlock = 393216;
  localparam longint unsigned SizeCeiling = 64'h1_FFFF_FFFF;
  localparam logic [TotalW-1:0] CapacityMax = '1;
  localparam int unsigned LongStall = 300;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned ItemsPerPhase = 100;

  typedef struct packed {
    logic [5:0]        pad;
    logic [CtxW-1:0]   context_len;
    logic              owns_extra;
    logic [LayerW-1:0] layer_hi;
    logic [LayerW-1:0] layer_lo;
    logic [SeqW-1:0]   seq_id;
  } request_t;

  typedef struct packed {
    logic [3:0]        pad;
    logic [TotalW-1:0] owned_total;
    logic [TotalW-1:0] reserved_total;
    logic [GenW-1:0]   generation;
    logic [BytesW-1:0] bytes;
    logic [StatusW-1:0] status;
  } outcome_t;

  class admission_scoreboard;
    slot_state_e       slot_state[SlotCount];
    logic [BytesW-1:0] slot_bytes[SlotCount];
    logic [GenW-1:0]   slot_gen[SlotCount];
    logic [TotalW-1:0] reserved_sum;
    logic [TotalW-1:0] owned_sum;
    logic [TotalW-1:0] capacity;
    logic [GenW-1:0]   next_gen;
    outcome_t          pending_outcomes[$];
    int                mismatches;

    function new();
      foreach (slot_state[i]) begin
        slot_state[i] = SLOT_FREE;
        slot_bytes[i] = '0;
        slot_gen[i] = '0;
      end
      reserved_sum = '0;
      owned_sum = '0;
      capacity = '0;
      next_gen = 1;
      mismatches = 0;
    endfunction

    function longint unsigned layer_cost(int unsigned layer, int unsigned ctx);
      if (layer < 2) return ShallowCost;
      if (layer % 2 == 0) return EvenBase + longint'(ctx / 4) * EvenStep;
      return OddBase + longint'(ctx / 128) * OddStep;
    endfunction

    // Returns 0 when the request is malformed.
    function bit request_size(request_t req, output logic [BytesW-1:0] size);
      longint unsigned total;
      total = 0;
      size = '0;
      if (req.layer_lo > req.layer_hi || req.layer_hi >= LayerLimit) return 0;
      if (req.context_len == 0 || req.context_len > ContextMax) return 0;
      for (int unsigned l = req.layer_lo; l <= req.layer_hi; l++)
        total += layer_cost(l, req.context_len);
      if (req.owns_extra) total += ExtraBlock;
      if (total > SizeCeiling) total = SizeCeiling;
      size = total[BytesW-1:0];
      return 1;
    endfunction

    // The 8-bit slot field can never reach the slot count, so no range check.
    function void note_request(mode_e mode, request_t req);
      outcome_t          r;
      logic [BytesW-1:0] size;
      logic [TotalW:0]   used;
      logic [TotalW-1:0] left;
      slot_state_e       st;
      r = '0;
      st = slot_state[req.seq_id];
      if (mode == MODE_RESERVE) begin
        if (!request_size(req, size)) begin
          r.status = STAT_BAD_ARG;
        end else begin
          used = reserved_sum + owned_sum;
          left = (used > capacity) ? '0 : capacity - used[TotalW-1:0];
          r.bytes = size;
          if (st != SLOT_FREE) begin
            r.status = STAT_ALREADY_LIVE;
          end else if (size > left) begin
            r.status = STAT_NO_CAPACITY;
          end else if (next_gen == 0) begin
            r.status = STAT_GEN_EXHAUSTED;
          end else begin
            r.status = STAT_OK;
            r.generation = next_gen;
            next_gen = next_gen + 1;
            reserved_sum = reserved_sum + size;
            slot_state[req.seq_id] = SLOT_RESERVED;
            slot_bytes[req.seq_id] = size;
            slot_gen[req.seq_id] = r.generation;
          end
        end
      end else begin
        if (st != SLOT_FREE) begin
          r.bytes = slot_bytes[req.seq_id];
          r.generation = slot_gen[req.seq_id];
        end
        case (mode)
          MODE_PUBLISH: begin
            if (st != SLOT_RESERVED) begin
              r.status = STAT_NOT_RESERVED;
            end else begin
              reserved_sum = reserved_sum - r.bytes;
              owned_sum = owned_sum + r.bytes;
              slot_state[req.seq_id] = SLOT_PUBLISHED;
            end
          end
          MODE_ROLLBACK: begin
            // Rolling back a free slot is harmless and reports ok.
            if (st == SLOT_PUBLISHED) begin
              r.status = STAT_NOT_RESERVED;
            end else if (st == SLOT_RESERVED) begin
              reserved_sum = reserved_sum - r.bytes;
              slot_state[req.seq_id] = SLOT_FREE;
            end
          end
          default: begin
            if (st != SLOT_PUBLISHED) begin
              r.status = STAT_NOT_PUBLISHED;
            end else begin
              owned_sum = owned_sum - r.bytes;
              slot_state[req.seq_id] = SLOT_FREE;
            end
          end
        endcase
      end
      r.reserved_total = reserved_sum;
      r.owned_total = owned_sum;
      pending_outcomes.push_back(r);
    endfunction

    function int pending();
      return pending_outcomes.size();
    endfunction

    task report_mismatch(string what);
      mismatches++;
      $display("ERROR: %s", what);
    endtask

    task check_outcome(outcome_t got);
      outcome_t want;
      if (pending_outcomes.size() == 0) begin
        report_mismatch("result arrived with no request outstanding");
        return;
      end
      want = pending_outcomes.pop_front();
      if (got.status !== want.status)
        report_mismatch($sformatf("status got %0d want %0d", got.status, want.status));
      if (got.bytes !== want.bytes)
        report_mismatch($sformatf("bytes got %0d want %0d", got.bytes, want.bytes));
      if (got.generation !== want.generation)
        report_mismatch($sformatf("generation got %0d want %0d",
                                  got.generation, want.generation));
      if (got.reserved_total !== want.reserved_total)
        report_mismatch($sformatf("reserved_total got %0d want %0d",
                                  got.reserved_total, want.reserved_total));
      if (got.owned_total !== want.owned_total)
        report_mismatch($sformatf("owned_total got %0d want %0d",
                                  got.owned_total, want.owned_total));
    endtask
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [TotalW-1:0]   cfg_wdata_i;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;
  logic [ModeW-1:0]    s_axis_tuser;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;

  admission_scoreboard sb;
  bit no_gap;
  bit hold_request;

  attention_state_capacity_admission dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // Result side: random back-pressure, plus one long hold-off on request.
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (LongStall) @(negedge clk_i);
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= no_gap || ($urandom_range(99) >= 36);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid === 1'b1 && m_axis_tready)
      sb.check_outcome(outcome_t'(m_axis_tdata));
  end

  task automatic send_item(mode_e mode, request_t req);
    @(negedge clk_i);
    while (!no_gap && $urandom_range(99) < 36) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= req;
    s_axis_tuser <= mode;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_request(mode, req);
  endtask

  task automatic send_fields(mode_e mode, int seq, int lo, int hi, int extra, int ctx);
    request_t req;
    req = '0;
    req.seq_id = SeqW'(seq);
    req.layer_lo = LayerW'(lo);
    req.layer_hi = LayerW'(hi);
    req.owns_extra = 1'(extra);
    req.context_len = CtxW'(ctx);
    send_item(mode, req);
  endtask

  // Lower valid, wait for every result, then let the pipeline settle.
  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_capacity(logic [TotalW-1:0] value);
    drain();
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    sb.capacity = value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Mostly well-formed traffic on a small pool of slots so that entries go
  // through their whole lifecycle; the rest is malformed reserves.
  function automatic void random_request(output mode_e mode, output request_t req);
    logic [63:0] noise;
    int pick;
    noise = {$urandom(), $urandom()};
    req = noise[InDataW-1:0];
    req.pad = '0;
    if ($urandom_range(99) < 75) req.seq_id = SeqW'($urandom_range(15));
    pick = $urandom_range(99);
    if (pick < 38) begin
      mode = MODE_RESERVE;
      req.layer_lo = LayerW'($urandom_range(LayerLimit - 1));
      req.layer_hi = LayerW'($urandom_range(LayerLimit - 1, req.layer_lo));
      case ($urandom_range(9))
        0: req.context_len = CtxW'(ContextMax);
        1, 2: req.context_len = CtxW'($urandom_range(ContextMax, 1));
        default: req.context_len = CtxW'($urandom_range(4096, 1));
      endcase
    end else if (pick < 46) begin
      mode = MODE_RESERVE;
      req.layer_lo = LayerW'($urandom_range(LayerLimit - 1));
      req.layer_hi = LayerW'($urandom_range(LayerLimit - 1, req.layer_lo));
      req.context_len = CtxW'($urandom_range(ContextMax, 1));
      case ($urandom_range(3))
        0: begin
          req.layer_hi = LayerW'($urandom_range(62));
          req.layer_lo = LayerW'($urandom_range(63, req.layer_hi + 1));
        end
        1: begin
          req.layer_hi = LayerW'($urandom_range(63, LayerLimit));
          req.layer_lo = LayerW'($urandom_range(req.layer_hi));
        end
        2: req.context_len = '0;
        default: req.context_len = CtxW'($urandom_range(21'h1F_FFFF, ContextMax + 1));
      endcase
    end else if (pick < 66) begin
      mode = MODE_PUBLISH;
    end else if (pick < 80) begin
      mode = MODE_ROLLBACK;
    end else begin
      mode = MODE_RELEASE;
    end
  endfunction

  initial begin
    mode_e             mode;
    request_t          req;
    logic [TotalW:0]   used;
    logic [TotalW-1:0] cap;
    sb = new();
    no_gap = 1'b0;
    hold_request = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = MODE_RESERVE;
    rst_ni = 1'b0;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;

    // No capacity: a refused reserve, malformed reserves, free-slot operations.
    write_capacity('0);
    send_fields(MODE_RESERVE, 0, 0, 1, 0, 1);
    send_fields(MODE_RESERVE, 1, 5, 4, 1, 100);
    send_fields(MODE_RESERVE, 1, 0, 43, 0, 100);
    send_fields(MODE_RESERVE, 1, 63, 63, 0, 100);
    send_fields(MODE_RESERVE, 1, 0, 3, 0, 0);
    send_fields(MODE_RESERVE, 1, 0, 3, 0, ContextMax + 1);
    send_fields(MODE_RESERVE, 1, 0, 3, 1, 21'h1F_FFFF);
    send_fields(MODE_PUBLISH, 3, 0, 0, 0, 0);
    send_fields(MODE_ROLLBACK, 3, 0, 0, 0, 0);
    send_fields(MODE_RELEASE, 3, 0, 0, 0, 0);

    // Full capacity: the largest request and the slot lifecycle.
    write_capacity(CapacityMax);
    send_fields(MODE_RESERVE, 255, 0, 42, 1, ContextMax);
    send_fields(MODE_RESERVE, 255, 0, 0, 0, 1);
    send_fields(MODE_ROLLBACK, 255, 0, 0, 0, 0);
    send_fields(MODE_RESERVE, 7, 2, 2, 0, 4);
    send_fields(MODE_PUBLISH, 7, 0, 0, 0, 0);
    send_fields(MODE_PUBLISH, 7, 0, 0, 0, 0);
    send_fields(MODE_ROLLBACK, 7, 0, 0, 0, 0);
    send_fields(MODE_RELEASE, 7, 0, 0, 0, 0);
    send_fields(MODE_RELEASE, 7, 0, 0, 0, 0);
    send_fields(MODE_RESERVE, 1, 3, 3, 0, 128);
    send_fields(MODE_RESERVE, 2, 0, 42, 0, ContextMax);
    send_fields(MODE_PUBLISH, 2, 0, 0, 0, 0);

    // Capacity written below what is already held leaves nothing free.
    write_capacity(40'd1000);
    send_fields(MODE_RESERVE, 9, 0, 0, 0, 1);

    for (int phase = 0; phase < 4; phase++) begin
      drain();
      used = sb.reserved_sum + sb.owned_sum;
      case (phase)
        0: cap = CapacityMax;
        1: cap = used[TotalW:1];
        2: cap = 40'd3_000_000_000;
        default: cap = {8'($urandom_range(255)), 32'($urandom())};
      endcase
      write_capacity(cap);
      no_gap = (phase == 2);
      if (phase == 1) hold_request = 1'b1;
      repeat (ItemsPerPhase) begin
        random_request(mode, req);
        send_item(mode, req);
      end
    end
    no_gap = 1'b0;
    drain();

    if (sb.mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
